FILE: src/nearest_neighbor_image_scaler_defines.svh
// Assertion macros shared by the scaler RTL.
// Every macro expects clk_i and rst_ni in the scope where it is used.
`ifndef NEAREST_NEIGHBOR_IMAGE_SCALER_DEFINES_SVH
`define NEAREST_NEIGHBOR_IMAGE_SCALER_DEFINES_SVH

// Implication property checked on every clock edge outside reset
`define NNIS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never be seen outside reset
`define NNIS_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

FILE: src/nnis_pkg.sv
// Shared types, widths and codes of the nearest-neighbor image scaler.
// No dependencies; every scaler module and the testbench import this package.
package nnis_pkg;

  // Default sizing of the block
  localparam int MAX_SRC_DIM         = 256;
  localparam int MAX_DST_DIM         = 1024;
  localparam int MAX_BYTES_PER_PIXEL = 4;

  // Field widths
  localparam int COORD_W   = 10;
  localparam int SRC_SZ_W  = 9;
  localparam int DST_SZ_W  = 11;
  localparam int BPP_W     = 3;
  localparam int PIX_W     = 32;
  localparam int PIX_BYTES = PIX_W / 8;
  localparam int MAP_W     = 8;
  localparam int OFF_W     = 22;

  // Divider: quotient never reaches the source size, so it fits its width
  localparam int QUOT_W  = SRC_SZ_W;
  localparam int DVD_W   = COORD_W + SRC_SZ_W;
  localparam int PROD_W  = COORD_W + DST_SZ_W;
  localparam int LIN_W   = PROD_W + 1;

  // Configuration port
  localparam int APB_AW = 5;
  localparam int APB_DW = 32;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_READ  = 1'b1
  } op_e;

  typedef enum logic {
    STATUS_DONE  = 1'b0,
    STATUS_RANGE = 1'b1
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIVX,
    S_DIVY,
    S_FIN
  } state_e;

  typedef struct packed {
    op_e                operation;
    logic [COORD_W-1:0] coord_x;
    logic [COORD_W-1:0] coord_y;
    logic [PIX_W-1:0]   pixel_in;
  } req_t;

  typedef struct packed {
    status_e            status;
    logic [PIX_W-1:0]   pixel_out;
    logic [MAP_W-1:0]   mapped_x;
    logic [MAP_W-1:0]   mapped_y;
    logic [OFF_W-1:0]   dest_byte_offset;
  } rsp_t;

  // Effective (clamped) configuration seen by the datapath
  typedef struct packed {
    logic [SRC_SZ_W-1:0] src_width;
    logic [SRC_SZ_W-1:0] src_height;
    logic [DST_SZ_W-1:0] dst_width;
    logic [DST_SZ_W-1:0] dst_height;
    logic [BPP_W-1:0]    bytes_per_pixel;
  } cfg_t;

endpackage

FILE: src/nnis_chan_if.sv
// Valid/ready channel carrying one payload item per transfer.
// Payload type is given by the instantiating level; no package dependency.
interface nnis_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: src/nnis_cfg_regs.sv
// APB-style configuration registers and their clamped effective values.
// Depends on nnis_pkg.
module nnis_cfg_regs #(
  parameter int MaxSrcDim       = nnis_pkg::MAX_SRC_DIM,
  parameter int MaxDstDim       = nnis_pkg::MAX_DST_DIM,
  parameter int MaxBytesPerPixel = nnis_pkg::MAX_BYTES_PER_PIXEL
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [nnis_pkg::APB_AW-1:0] paddr,
  input  logic [nnis_pkg::APB_DW-1:0] pwdata,
  output logic [nnis_pkg::APB_DW-1:0] prdata,
  output logic                        pready,
  output nnis_pkg::cfg_t              cfg_o
);
  import nnis_pkg::*;

  localparam logic [2:0] REG_SRC_WIDTH  = 3'd0;
  localparam logic [2:0] REG_SRC_HEIGHT = 3'd1;
  localparam logic [2:0] REG_DST_WIDTH  = 3'd2;
  localparam logic [2:0] REG_DST_HEIGHT = 3'd3;
  localparam logic [2:0] REG_BPP        = 3'd4;

  logic [SRC_SZ_W-1:0] src_width_q, src_height_q;
  logic [DST_SZ_W-1:0] dst_width_q, dst_height_q;
  logic [BPP_W-1:0]    bpp_q;
  logic [2:0]          reg_idx;
  logic                wr_en;

  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // Write the addressed register at the end of the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_width_q  <= SRC_SZ_W'(256);
      src_height_q <= SRC_SZ_W'(256);
      dst_width_q  <= DST_SZ_W'(256);
      dst_height_q <= DST_SZ_W'(256);
      bpp_q        <= BPP_W'(4);
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_SRC_WIDTH:  src_width_q  <= pwdata[SRC_SZ_W-1:0];
        REG_SRC_HEIGHT: src_height_q <= pwdata[SRC_SZ_W-1:0];
        REG_DST_WIDTH:  dst_width_q  <= pwdata[DST_SZ_W-1:0];
        REG_DST_HEIGHT: dst_height_q <= pwdata[DST_SZ_W-1:0];
        REG_BPP:        bpp_q        <= pwdata[BPP_W-1:0];
        default: ;
      endcase
    end
  end

  // Return the stored bits on a read
  always_comb begin
    unique case (reg_idx)
      REG_SRC_WIDTH:  prdata = APB_DW'(src_width_q);
      REG_SRC_HEIGHT: prdata = APB_DW'(src_height_q);
      REG_DST_WIDTH:  prdata = APB_DW'(dst_width_q);
      REG_DST_HEIGHT: prdata = APB_DW'(dst_height_q);
      REG_BPP:        prdata = APB_DW'(bpp_q);
      default:        prdata = '0;
    endcase
  end

  // Clamp each size into its legal range; zero acts as one
  always_comb begin
    cfg_o = '0;
    if (src_width_q == '0) cfg_o.src_width = SRC_SZ_W'(1);
    else if (32'(src_width_q) > MaxSrcDim) cfg_o.src_width = SRC_SZ_W'(MaxSrcDim);
    else cfg_o.src_width = src_width_q;

    if (src_height_q == '0) cfg_o.src_height = SRC_SZ_W'(1);
    else if (32'(src_height_q) > MaxSrcDim) cfg_o.src_height = SRC_SZ_W'(MaxSrcDim);
    else cfg_o.src_height = src_height_q;

    if (dst_width_q == '0) cfg_o.dst_width = DST_SZ_W'(1);
    else if (32'(dst_width_q) > MaxDstDim) cfg_o.dst_width = DST_SZ_W'(MaxDstDim);
    else cfg_o.dst_width = dst_width_q;

    if (dst_height_q == '0) cfg_o.dst_height = DST_SZ_W'(1);
    else if (32'(dst_height_q) > MaxDstDim) cfg_o.dst_height = DST_SZ_W'(MaxDstDim);
    else cfg_o.dst_height = dst_height_q;

    if (bpp_q == '0) cfg_o.bytes_per_pixel = BPP_W'(1);
    else if (32'(bpp_q) > MaxBytesPerPixel) cfg_o.bytes_per_pixel = BPP_W'(MaxBytesPerPixel);
    else cfg_o.bytes_per_pixel = bpp_q;
  end

endmodule

FILE: src/nnis_div.sv
// Restoring divider, one quotient bit per cycle, for the coordinate mapping.
// Depends on nnis_pkg. Caller guarantees the quotient fits QUOT_W bits.
module nnis_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [nnis_pkg::DVD_W-1:0]    dividend_i,
  input  logic [nnis_pkg::DST_SZ_W-1:0] divisor_i,
  output logic                          busy_o,
  output logic                          done_o,
  output logic [nnis_pkg::QUOT_W-1:0]   quot_o
);
  import nnis_pkg::*;

  localparam int CntW = $clog2(QUOT_W + 1);

  logic [DST_SZ_W-1:0] rem_q, rem_d;
  logic [DST_SZ_W-1:0] dvs_q;
  logic [QUOT_W-1:0]   quo_q;
  logic [CntW-1:0]     cnt_q;
  logic                busy_q, done_q;
  logic [DST_SZ_W:0]   trial;
  logic                fits;

  // Shift in the next dividend bit and try the subtraction
  always_comb begin
    trial = {rem_q, quo_q[QUOT_W-1]};
    fits  = trial >= {1'b0, dvs_q};
    rem_d = fits ? DST_SZ_W'(trial - {1'b0, dvs_q}) : trial[DST_SZ_W-1:0];
  end

  // Sequence the iterations
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(QUOT_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient; low dividend bits turn into quotient bits
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= DST_SZ_W'(dividend_i[DVD_W-1:QUOT_W]);
      quo_q <= dividend_i[QUOT_W-1:0];
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[QUOT_W-2:0], fits};
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

FILE: src/nnis_frame_store.sv
// Source frame store: single-port synchronous RAM, registered read data.
// Depends on nnis_pkg for the pixel width.
module nnis_frame_store #(
  parameter int Depth = nnis_pkg::MAX_SRC_DIM * nnis_pkg::MAX_SRC_DIM,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic                       re_i,
  input  logic [AddrW-1:0]           addr_i,
  input  logic [nnis_pkg::PIX_W-1:0] wdata_i,
  output logic [nnis_pkg::PIX_W-1:0] rdata_o
);
  import nnis_pkg::*;

  logic [PIX_W-1:0] mem_q [Depth];
  logic [PIX_W-1:0] rdata_q;

  // Write or read one entry per cycle; read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/nearest_neighbor_image_scaler.sv
// Nearest-neighbor image scaler top level: sequencer and result register.
// Depends on nnis_pkg, nnis_chan_if, nnis_cfg_regs, nnis_div, nnis_frame_store.
//
//   Channel  Dir  Payload  Handshake
//   req_i    in   req_t    valid/ready, transfer when both high
//   rsp_o    out  rsp_t    valid/ready, transfer when both high
//   APB      in   32 bit   write at psel & penable & pwrite, pready tied high
//
// A write or an out-of-range item goes from transfer through the check and final
// states to the next transfer; an in-range read also makes two 9-step runs of the
// shared divider (x then y) followed by one frame store read.
// One item is worked on at a time; the next is taken while a result waits.
// A stalled result holds the block in its final state. Reset clears control
// only; the frame store needs no clearing.
module nearest_neighbor_image_scaler #(
  parameter int MaxSrcDim        = nnis_pkg::MAX_SRC_DIM,
  parameter int MaxDstDim        = nnis_pkg::MAX_DST_DIM,
  parameter int MaxBytesPerPixel = nnis_pkg::MAX_BYTES_PER_PIXEL
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  nnis_chan_if.sink                   req_i,
  nnis_chan_if.source                 rsp_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [nnis_pkg::APB_AW-1:0] paddr,
  input  logic [nnis_pkg::APB_DW-1:0] pwdata,
  output logic [nnis_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);
  import nnis_pkg::*;

  `include "nearest_neighbor_image_scaler_defines.svh"

  localparam int Depth = MaxSrcDim * MaxSrcDim;
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;

  cfg_t cfg;

  state_e state_q, state_d;

  op_e                 op_q;
  logic [COORD_W-1:0]  cx_q, cy_q;
  logic [PIX_W-1:0]    pix_q;
  logic                oor_q;
  logic [PROD_W-1:0]   prod_q;
  logic [LIN_W-1:0]    lin_q;
  logic [OFF_W-1:0]    off_q;
  logic [QUOT_W-1:0]   sx_q, sy_q;
  rsp_t                rsp_q, rsp_d;
  logic                rsp_valid_q;

  logic                oor;
  logic                accept, load;
  logic                div_start, div_busy, div_done;
  logic [QUOT_W-1:0]   quot, quot_clamped;
  logic [COORD_W-1:0]  dvd_coord;
  logic [SRC_SZ_W-1:0] dvd_size, map_size;
  logic [DST_SZ_W-1:0] dvs;
  logic [DVD_W-1:0]    dividend;
  logic                mem_we, mem_re;
  logic [QUOT_W-1:0]   addr_x, addr_y;
  logic [AddrW-1:0]    mem_addr;
  logic [PIX_W-1:0]    mem_rdata, pix_masked;

  nnis_cfg_regs #(
    .MaxSrcDim        (MaxSrcDim),
    .MaxDstDim        (MaxDstDim),
    .MaxBytesPerPixel (MaxBytesPerPixel)
  ) u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  nnis_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (dvs),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  nnis_frame_store #(
    .Depth (Depth),
    .AddrW (AddrW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i (pix_q),
    .rdata_o (mem_rdata)
  );

  assign accept = req_i.valid && req_i.ready;
  assign load   = (state_q == S_FIN) && (!rsp_valid_q || rsp_o.ready);

  // Range check of the held item against the effective sizes
  always_comb begin
    if (op_q == OP_WRITE) begin
      oor = ({1'b0, cx_q} >= {2'b0, cfg.src_width}) ||
            ({1'b0, cy_q} >= {2'b0, cfg.src_height});
    end else begin
      oor = ({1'b0, cx_q} >= cfg.dst_width) || ({1'b0, cy_q} >= cfg.dst_height);
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (accept) state_d = S_CHECK;
      S_CHECK: state_d = (op_q == OP_READ && !oor) ? S_DIVX : S_FIN;
      S_DIVX:  if (div_done) state_d = S_DIVY;
      S_DIVY:  if (div_done) state_d = S_FIN;
      S_FIN:   if (load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Control outputs of the sequencer
  always_comb begin
    req_i.ready = 1'b0;
    div_start   = 1'b0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    unique case (state_q)
      S_IDLE:  req_i.ready = 1'b1;
      S_CHECK: begin
        div_start = (op_q == OP_READ) && !oor;
        mem_we    = (op_q == OP_WRITE) && !oor;
      end
      S_DIVX:  div_start = div_done;
      S_DIVY:  mem_re = div_done;
      S_FIN:   ;
      default: ;
    endcase
  end

  // Divider operands: x mapping first, y mapping second
  always_comb begin
    if (state_q == S_CHECK) begin
      dvd_coord = cx_q;
      dvd_size  = cfg.src_width;
      dvs       = cfg.dst_width;
    end else begin
      dvd_coord = cy_q;
      dvd_size  = cfg.src_height;
      dvs       = cfg.dst_height;
    end
    dividend = DVD_W'(dvd_coord) * DVD_W'(dvd_size);
  end

  // Clamp the quotient to the last column or row
  assign map_size     = (state_q == S_DIVX) ? cfg.src_width : cfg.src_height;
  assign quot_clamped = (quot >= map_size) ? QUOT_W'(map_size - 1'b1) : quot;

  // Store address: written coordinate or mapped source coordinate
  always_comb begin
    if (state_q == S_CHECK) begin
      addr_x = QUOT_W'(cx_q);
      addr_y = QUOT_W'(cy_q);
    end else begin
      addr_x = sx_q;
      addr_y = quot_clamped;
    end
    mem_addr = AddrW'(32'(addr_y) * MaxSrcDim + 32'(addr_x));
  end

  // Keep the low bytes_per_pixel bytes
  always_comb begin
    for (int b = 0; b < PIX_BYTES; b++) begin
      pix_masked[8*b +: 8] = (b < 32'(cfg.bytes_per_pixel)) ? mem_rdata[8*b +: 8] : 8'h00;
    end
  end

  // Result fields; everything but status is zero for writes and rejects
  always_comb begin
    rsp_d        = '0;
    rsp_d.status = oor_q ? STATUS_RANGE : STATUS_DONE;
    if (op_q == OP_READ && !oor_q) begin
      rsp_d.pixel_out        = pix_masked;
      rsp_d.mapped_x         = sx_q[MAP_W-1:0];
      rsp_d.mapped_y         = sy_q[MAP_W-1:0];
      rsp_d.dest_byte_offset = off_q;
    end
  end

  // State and result handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers: hold the item, build the offset, capture mappings
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= req_i.data.operation;
      cx_q  <= req_i.data.coord_x;
      cy_q  <= req_i.data.coord_y;
      pix_q <= req_i.data.pixel_in;
    end
    if (state_q == S_CHECK) begin
      oor_q  <= oor;
      prod_q <= PROD_W'(cy_q) * PROD_W'(cfg.dst_width);
    end
    if (state_q == S_DIVX) begin
      lin_q <= LIN_W'(prod_q) + LIN_W'(cx_q);
      if (div_done) sx_q <= quot_clamped;
    end
    if (state_q == S_DIVY) begin
      off_q <= OFF_W'(lin_q) * OFF_W'(cfg.bytes_per_pixel);
      if (div_done) sy_q <= quot_clamped;
    end
    if (load) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_q;

  `NNIS_ASSERT(a_div_start_idle, div_start |-> !div_busy, "divider restarted while busy")
  `NNIS_ASSERT(a_div_done_state,
      div_done |-> (state_q == S_DIVX || state_q == S_DIVY),
      "divider result outside mapping states")
  `NNIS_ASSERT(a_map_x_bound,
      (load && op_q == OP_READ && !oor_q) |-> (sx_q < cfg.src_width),
      "mapped column beyond source width")
  `NNIS_ASSERT(a_map_y_bound,
      (load && op_q == OP_READ && !oor_q) |-> (sy_q < cfg.src_height),
      "mapped row beyond source height")
  `NNIS_ASSERT_NEVER(a_store_busy_accept,
      accept && (mem_we || mem_re || div_busy),
      "item taken while store or divider busy")

endmodule

FILE: test/tb_nearest_neighbor_image_scaler.sv
// Self-checking testbench for the scaler: directed table, then random phases.
// Depends on nnis_pkg, nnis_chan_if and the nearest_neighbor_image_scaler RTL.
`timescale 1ns / 1ps

module tb_nearest_neighbor_image_scaler;
  import nnis_pkg::*;

  typedef enum int unsigned {
    REG_SRC_WIDTH       = 0,
    REG_SRC_HEIGHT      = 1,
    REG_DST_WIDTH       = 2,
    REG_DST_HEIGHT      = 3,
    REG_BYTES_PER_PIXEL = 4
  } reg_idx_e;

  typedef enum logic {
    ROW_ITEM,
    ROW_CFG
  } row_kind_e;

  // One line of the directed table: either a register write or an item
  typedef struct {
    row_kind_e   kind;
    reg_idx_e    reg_idx;
    logic [31:0] reg_val;
    req_t        req;
    bit          typed;
    rsp_t        rsp;
  } stim_row_t;

  typedef struct {
    bit   typed;
    rsp_t rsp;
  } fixed_rsp_t;

  // Clamped sizes the datapath works with
  typedef struct {
    int unsigned sw;
    int unsigned sh;
    int unsigned dw;
    int unsigned dh;
    int unsigned bpp;
  } eff_cfg_t;

  logic clk_i;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic pready;

  nnis_chan_if #(.T(req_t)) req_if ();
  nnis_chan_if #(.T(rsp_t)) rsp_if ();

  nearest_neighbor_image_scaler u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_if),
    .rsp_o   (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow of the registers and the frame store
  cfg_t        cfg_shadow;
  logic [31:0] frame_mem [0:MAX_SRC_DIM*MAX_SRC_DIM-1];
  bit          filled    [0:MAX_SRC_DIM*MAX_SRC_DIM-1];

  rsp_t        pending_rsp [$];
  fixed_rsp_t  fixed_rsp_q [$];
  stim_row_t   dir_rows [$];
  int unsigned n_sent;
  int unsigned n_done;
  int unsigned err_count;
  bit          no_idle;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("nearest_neighbor_image_scaler: mismatch");
    $finish;
  end

  function automatic int unsigned clamp_cfg(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic eff_cfg_t current_eff();
    eff_cfg_t e;
    e.sw  = clamp_cfg(cfg_shadow.src_width, MAX_SRC_DIM);
    e.sh  = clamp_cfg(cfg_shadow.src_height, MAX_SRC_DIM);
    e.dw  = clamp_cfg(cfg_shadow.dst_width, MAX_DST_DIM);
    e.dh  = clamp_cfg(cfg_shadow.dst_height, MAX_DST_DIM);
    e.bpp = clamp_cfg(cfg_shadow.bytes_per_pixel, MAX_BYTES_PER_PIXEL);
    return e;
  endfunction

  // Source coordinate chosen for a destination coordinate, exact integer ratio
  function automatic int unsigned map_axis(int unsigned d, int unsigned s, int unsigned dsz);
    int unsigned q;
    q = (d * s) / dsz;
    if (q >= s) q = s - 1;
    return q;
  endfunction

  // Predict one result and advance the shadow store
  function automatic rsp_t scale_lookup(req_t r);
    eff_cfg_t    e;
    rsp_t        o;
    int unsigned sx;
    int unsigned sy;
    logic [31:0] mask;
    e = current_eff();
    o = '0;
    o.status = STATUS_DONE;
    if (r.operation == OP_WRITE) begin
      if (r.coord_x >= e.sw || r.coord_y >= e.sh) begin
        o.status = STATUS_RANGE;
      end else begin
        frame_mem[r.coord_y * MAX_SRC_DIM + r.coord_x] = r.pixel_in;
      end
    end else if (r.coord_x >= e.dw || r.coord_y >= e.dh) begin
      o.status = STATUS_RANGE;
    end else begin
      sx   = map_axis(r.coord_x, e.sw, e.dw);
      sy   = map_axis(r.coord_y, e.sh, e.dh);
      mask = (e.bpp >= 4) ? 32'hFFFF_FFFF : ((32'd1 << (8 * e.bpp)) - 32'd1);
      o.pixel_out        = frame_mem[sy * MAX_SRC_DIM + sx] & mask;
      o.mapped_x         = MAP_W'(sx);
      o.mapped_y         = MAP_W'(sy);
      o.dest_byte_offset = OFF_W'((r.coord_y * e.dw + r.coord_x) * e.bpp);
    end
    return o;
  endfunction

  function automatic stim_row_t cfg_row(reg_idx_e idx, logic [31:0] val);
    stim_row_t row;
    row.kind    = ROW_CFG;
    row.reg_idx = idx;
    row.reg_val = val;
    row.req     = '0;
    row.typed   = 1'b0;
    row.rsp     = '0;
    return row;
  endfunction

  function automatic stim_row_t item_row(op_e op, int unsigned x, int unsigned y,
                                         logic [31:0] pix);
    stim_row_t row;
    row.kind             = ROW_ITEM;
    row.reg_idx          = REG_SRC_WIDTH;
    row.reg_val          = '0;
    row.req              = '0;
    row.typed            = 1'b0;
    row.rsp              = '0;
    row.req.operation    = op;
    row.req.coord_x      = COORD_W'(x);
    row.req.coord_y      = COORD_W'(y);
    row.req.pixel_in     = pix;
    return row;
  endfunction

  function automatic stim_row_t typed_row(op_e op, int unsigned x, int unsigned y,
                                          logic [31:0] pix, status_e st, logic [31:0] po,
                                          int unsigned mx, int unsigned my, int unsigned off);
    stim_row_t row;
    row                      = item_row(op, x, y, pix);
    row.typed                = 1'b1;
    row.rsp.status           = st;
    row.rsp.pixel_out        = po;
    row.rsp.mapped_x         = MAP_W'(mx);
    row.rsp.mapped_y         = MAP_W'(my);
    row.rsp.dest_byte_offset = OFF_W'(off);
    return row;
  endfunction

  // Pick a register value: extremes, out-of-range bits, or a random legal size
  function automatic logic [31:0] pick_size(int unsigned hi, int unsigned field_max);
    case ($urandom_range(0, 11))
      0: return 32'd1;
      1: return 32'(hi);
      2: return $urandom_range(0, 1) ? 32'd0 : 32'($urandom_range(hi + 1, field_max));
      3, 4, 5: return 32'($urandom_range(1, (hi > 8) ? 8 : hi));
      default: return 32'($urandom_range(1, hi));
    endcase
  endfunction

  // Random item, mostly in range for the current sizes, some edges and noise
  function automatic req_t random_item();
    req_t        r;
    eff_cfg_t    e;
    int unsigned lim_x;
    int unsigned lim_y;
    e = current_eff();
    r.operation = ($urandom_range(0, 99) < 55) ? OP_READ : OP_WRITE;
    r.pixel_in  = $urandom();
    lim_x = (r.operation == OP_READ) ? e.dw : e.sw;
    lim_y = (r.operation == OP_READ) ? e.dh : e.sh;
    case ($urandom_range(0, 9))
      0: begin
        r.coord_x = COORD_W'($urandom_range(0, 1023));
        r.coord_y = COORD_W'($urandom_range(0, 1023));
      end
      1: begin
        r.coord_x = COORD_W'(lim_x - 1);
        r.coord_y = COORD_W'(lim_y - 1);
      end
      2: begin
        r.coord_x = COORD_W'((lim_x > 1023) ? 1023 : lim_x);
        r.coord_y = COORD_W'($urandom_range(0, lim_y - 1));
      end
      3: begin
        r.coord_x = COORD_W'($urandom_range(0, lim_x - 1));
        r.coord_y = COORD_W'((lim_y > 1023) ? 1023 : lim_y);
      end
      default: begin
        r.coord_x = COORD_W'($urandom_range(0, lim_x - 1));
        r.coord_y = COORD_W'($urandom_range(0, lim_y - 1));
      end
    endcase
    return r;
  endfunction

  task automatic report(string what, logic [31:0] want, logic [31:0] got);
    err_count++;
    $display("%0t ns: %s expected %0h, got %0h", $time, what, want, got);
  endtask

  // Present one item and hold it until the transfer
  task automatic transfer(req_t r, bit typed, rsp_t typed_rsp);
    eff_cfg_t e;
    while (!no_idle && $urandom_range(0, 99) < 8) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= r;
    fixed_rsp_q.push_back('{typed: typed, rsp: typed_rsp});
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    n_sent++;
    e = current_eff();
    if (r.operation == OP_WRITE && r.coord_x < e.sw && r.coord_y < e.sh) begin
      filled[r.coord_y * MAX_SRC_DIM + r.coord_x] = 1'b1;
    end
  endtask

  // Send an item; a read of a source pixel not yet written gets a write first
  task automatic issue(req_t r, bit typed, rsp_t typed_rsp);
    eff_cfg_t    e;
    req_t        fill;
    int unsigned sx;
    int unsigned sy;
    e = current_eff();
    if (r.operation == OP_READ && r.coord_x < e.dw && r.coord_y < e.dh) begin
      sx = map_axis(r.coord_x, e.sw, e.dw);
      sy = map_axis(r.coord_y, e.sh, e.dh);
      if (!filled[sy * MAX_SRC_DIM + sx]) begin
        fill.operation = OP_WRITE;
        fill.coord_x   = COORD_W'(sx);
        fill.coord_y   = COORD_W'(sy);
        fill.pixel_in  = $urandom();
        transfer(fill, 1'b0, '0);
      end
    end
    transfer(r, typed, typed_rsp);
  endtask

  // Drain the block, write one register over APB and read it back
  task automatic write_reg(reg_idx_e idx, logic [31:0] val);
    logic [31:0] kept;
    req_if.valid <= 1'b0;
    while (n_done != n_sent) @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'(4 * int'(idx));
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      REG_SRC_WIDTH: begin
        cfg_shadow.src_width = val[SRC_SZ_W-1:0];
        kept = 32'(cfg_shadow.src_width);
      end
      REG_SRC_HEIGHT: begin
        cfg_shadow.src_height = val[SRC_SZ_W-1:0];
        kept = 32'(cfg_shadow.src_height);
      end
      REG_DST_WIDTH: begin
        cfg_shadow.dst_width = val[DST_SZ_W-1:0];
        kept = 32'(cfg_shadow.dst_width);
      end
      REG_DST_HEIGHT: begin
        cfg_shadow.dst_height = val[DST_SZ_W-1:0];
        kept = 32'(cfg_shadow.dst_height);
      end
      default: begin
        cfg_shadow.bytes_per_pixel = val[BPP_W-1:0];
        kept = 32'(cfg_shadow.bytes_per_pixel);
      end
    endcase
    // Read back: register keeps the bits written
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== kept) report($sformatf("register %0d readback", int'(idx)), kept, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Queue the expected result of each accepted item: table result or prediction
  always @(posedge clk_i) begin
    rsp_t       pred;
    fixed_rsp_t tag;
    if (rst_ni && req_if.valid && req_if.ready) begin
      pred = scale_lookup(req_if.data);
      tag  = '{typed: 1'b0, rsp: '0};
      if (fixed_rsp_q.size() != 0) tag = fixed_rsp_q.pop_front();
      pending_rsp.push_back(tag.typed ? tag.rsp : pred);
    end
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk_i) begin
    rsp_t want;
    rsp_t got;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      got = rsp_if.data;
      if (pending_rsp.size() == 0) begin
        report("result with nothing pending, status", 32'd0, 32'(got.status));
      end else begin
        want = pending_rsp.pop_front();
        if (got.status !== want.status)
          report("status", 32'(want.status), 32'(got.status));
        if (got.pixel_out !== want.pixel_out)
          report("pixel_out", want.pixel_out, got.pixel_out);
        if (got.mapped_x !== want.mapped_x)
          report("mapped_x", 32'(want.mapped_x), 32'(got.mapped_x));
        if (got.mapped_y !== want.mapped_y)
          report("mapped_y", 32'(want.mapped_y), 32'(got.mapped_y));
        if (got.dest_byte_offset !== want.dest_byte_offset)
          report("dest_byte_offset", 32'(want.dest_byte_offset), 32'(got.dest_byte_offset));
      end
      n_done++;
    end
  end

  // Result side: stall at random unless idling is off
  initial begin
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      rsp_if.ready <= no_idle || ($urandom_range(0, 99) >= 8);
    end
  end

  // Main sequence
  initial begin
    rst_ni       = 1'b0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    req_if.valid <= 1'b0;
    req_if.data  <= '0;
    no_idle     <= 1'b0;
    n_sent    = 0;
    n_done    = 0;
    err_count = 0;
    cfg_shadow.src_width       = SRC_SZ_W'(256);
    cfg_shadow.src_height      = SRC_SZ_W'(256);
    cfg_shadow.dst_width       = DST_SZ_W'(256);
    cfg_shadow.dst_height      = DST_SZ_W'(256);
    cfg_shadow.bytes_per_pixel = BPP_W'(4);
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset sizes: corners, range checks on both operations
    dir_rows.push_back(typed_row(OP_WRITE, 0, 0, 32'hFFFF_FFFF, STATUS_DONE, 0, 0, 0, 0));
    dir_rows.push_back(typed_row(OP_WRITE, 255, 255, 32'hA5A5_5A5A, STATUS_DONE, 0, 0, 0, 0));
    dir_rows.push_back(typed_row(OP_WRITE, 256, 0, 32'h1234_5678, STATUS_RANGE, 0, 0, 0, 0));
    dir_rows.push_back(typed_row(OP_WRITE, 0, 1023, 32'hFFFF_FFFF, STATUS_RANGE, 0, 0, 0, 0));
    dir_rows.push_back(typed_row(OP_READ, 0, 0, 0, STATUS_DONE, 32'hFFFF_FFFF, 0, 0, 0));
    dir_rows.push_back(typed_row(OP_READ, 255, 255, 0, STATUS_DONE, 32'hA5A5_5A5A,
                                 255, 255, 262140));
    dir_rows.push_back(typed_row(OP_READ, 256, 0, 0, STATUS_RANGE, 0, 0, 0, 0));
    dir_rows.push_back(typed_row(OP_READ, 1023, 1023, 32'hFFFF_FFFF, STATUS_RANGE, 0, 0, 0, 0));
    dir_rows.push_back(item_row(OP_WRITE, 128, 64, 32'h1234_5678));
    dir_rows.push_back(item_row(OP_READ, 128, 64, 0));
    // Pixel width: one byte, zero and oversize settings, two bytes
    dir_rows.push_back(cfg_row(REG_BYTES_PER_PIXEL, 32'd1));
    dir_rows.push_back(typed_row(OP_READ, 255, 255, 0, STATUS_DONE, 32'h0000_005A,
                                 255, 255, 65535));
    dir_rows.push_back(cfg_row(REG_BYTES_PER_PIXEL, 32'd0));
    dir_rows.push_back(item_row(OP_READ, 255, 255, 0));
    dir_rows.push_back(cfg_row(REG_BYTES_PER_PIXEL, 32'd7));
    dir_rows.push_back(item_row(OP_READ, 0, 1, 0));
    dir_rows.push_back(cfg_row(REG_BYTES_PER_PIXEL, 32'd2));
    dir_rows.push_back(item_row(OP_READ, 128, 64, 0));
    // Zero source size acts as one pixel
    dir_rows.push_back(cfg_row(REG_SRC_WIDTH, 32'd0));
    dir_rows.push_back(cfg_row(REG_SRC_HEIGHT, 32'd0));
    dir_rows.push_back(typed_row(OP_WRITE, 1, 0, 32'hDEAD_BEEF, STATUS_RANGE, 0, 0, 0, 0));
    dir_rows.push_back(item_row(OP_WRITE, 0, 0, 32'h0BAD_F00D));
    // Largest destination, then oversize and zero destination sizes
    dir_rows.push_back(cfg_row(REG_DST_WIDTH, 32'd1024));
    dir_rows.push_back(cfg_row(REG_DST_HEIGHT, 32'd1024));
    dir_rows.push_back(item_row(OP_READ, 1023, 1023, 0));
    dir_rows.push_back(cfg_row(REG_DST_WIDTH, 32'd2047));
    dir_rows.push_back(cfg_row(REG_DST_HEIGHT, 32'd0));
    dir_rows.push_back(item_row(OP_READ, 1023, 0, 0));
    dir_rows.push_back(typed_row(OP_READ, 0, 1, 0, STATUS_RANGE, 0, 0, 0, 0));
    // Oversize source sizes act as the largest
    dir_rows.push_back(cfg_row(REG_SRC_WIDTH, 32'd511));
    dir_rows.push_back(cfg_row(REG_SRC_HEIGHT, 32'd300));
    dir_rows.push_back(item_row(OP_READ, 1023, 0, 0));
    dir_rows.push_back(item_row(OP_WRITE, 255, 255, 32'h0000_0000));

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
      end else begin
        issue(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].rsp);
      end
    end

    // Random phases: smallest sizes, largest sizes, then random settings
    for (int phase = 0; phase < 10; phase++) begin
      no_idle <= (phase == 4);
      if (phase == 0) begin
        write_reg(REG_SRC_WIDTH, 32'd1);
        write_reg(REG_SRC_HEIGHT, 32'd1);
        write_reg(REG_DST_WIDTH, 32'd1);
        write_reg(REG_DST_HEIGHT, 32'd1);
        write_reg(REG_BYTES_PER_PIXEL, 32'd1);
      end else if (phase == 1) begin
        write_reg(REG_SRC_WIDTH, 32'd256);
        write_reg(REG_SRC_HEIGHT, 32'd256);
        write_reg(REG_DST_WIDTH, 32'd1024);
        write_reg(REG_DST_HEIGHT, 32'd1024);
        write_reg(REG_BYTES_PER_PIXEL, 32'd4);
      end else begin
        write_reg(REG_SRC_WIDTH, pick_size(MAX_SRC_DIM, 511));
        write_reg(REG_SRC_HEIGHT, pick_size(MAX_SRC_DIM, 511));
        write_reg(REG_DST_WIDTH, pick_size(MAX_DST_DIM, 2047));
        write_reg(REG_DST_HEIGHT, pick_size(MAX_DST_DIM, 2047));
        write_reg(REG_BYTES_PER_PIXEL, pick_size(MAX_BYTES_PER_PIXEL, 7));
      end
      repeat (45) issue(random_item(), 1'b0, '0);
    end

    // Drain, let the last result settle, then judge
    req_if.valid <= 1'b0;
    while (n_done != n_sent) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (pending_rsp.size() != 0) report("results still pending", 32'd0, pending_rsp.size());
    if (err_count == 0) begin
      $display("nearest_neighbor_image_scaler: match");
    end else begin
      $display("nearest_neighbor_image_scaler: mismatch");
    end
    $finish;
  end

endmodule

FILE: nearest_neighbor_image_scaler.f
+incdir+src
src/nnis_pkg.sv
src/nnis_chan_if.sv
src/nnis_cfg_regs.sv
src/nnis_div.sv
src/nnis_frame_store.sv
src/nearest_neighbor_image_scaler.sv
test/tb_nearest_neighbor_image_scaler.sv
